// ===== hw/rtl/pmag_pkg.sv =====
// shared types, widths and helpers for the poly matrix address generator
package pmag_pkg;

	localparam int DIM_W    = 9;   // matrix width / height register
	localparam int STEP_W   = 17;  // signed channel step
	localparam int OFF_W    = 10;  // signed x / y offsets
	localparam int LVL_W    = 17;  // signed q1.15 control levels
	localparam int ADDR_W   = 16;  // address field on the output word
	localparam int N_W      = 18;  // cell count, up to 511*511
	localparam int MUL_W    = 19;  // signed operand width of the shared multiplier
	localparam int PROD_W   = 2 * MUL_W;
	localparam int FRAC     = 15;  // level scale is 2^15
	localparam int TRUNC_W  = PROD_W - FRAC;
	localparam int COORD_W  = 12;  // signed row coordinate after scaling
	localparam int ACC_W    = 22;  // signed raw address
	localparam int DIV_BITS = 20;  // nonnegative raw address always fits here
	localparam int CNT_W    = $clog2(DIV_BITS + 1);
	localparam int CFG_AW   = 4;
	localparam int CFG_DW   = 32;

	localparam logic [CFG_AW-3:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_AW-3:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_AW-3:0] REG_STEP   = 2'd2;

	localparam logic [PROD_W-1:0] FRAC_BIAS = PROD_W'((64'd1 << FRAC) - 64'd1);

	// effective configuration, dimensions already clamped
	typedef struct packed {
		logic [DIM_W-1:0]         width;
		logic [DIM_W-1:0]         height;
		logic signed [STEP_W-1:0] step;
	} cfg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mod_stat_t;

	// divide by 2^15 rounding toward zero
	function automatic logic signed [TRUNC_W-1:0] trunc_frac(input logic signed [PROD_W-1:0] p);
		logic [PROD_W-1:0] b;
		b = p + (p[PROD_W-1] ? FRAC_BIAS : '0);
		return b[PROD_W-1:FRAC];
	endfunction

endpackage

// ===== hw/rtl/pmag_cfg.sv =====
// register file behind the apb port, with dimension clamping
module pmag_cfg #(
	parameter int DIM_MAX = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pmag_pkg::CFG_AW-1:0]   paddr,
	input  logic [pmag_pkg::CFG_DW-1:0]   pwdata,
	output logic [pmag_pkg::CFG_DW-1:0]   prdata,
	output pmag_pkg::cfg_t                cfg
);

	logic [pmag_pkg::DIM_W-1:0]         width_q;
	logic [pmag_pkg::DIM_W-1:0]         height_q;
	logic signed [pmag_pkg::STEP_W-1:0] step_q;
	logic [pmag_pkg::CFG_AW-3:0]        idx;
	logic                               wr;

	assign idx = paddr[pmag_pkg::CFG_AW-1:2];
	assign wr  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= pmag_pkg::DIM_W'(16);
			height_q <= pmag_pkg::DIM_W'(16);
			step_q   <= pmag_pkg::STEP_W'(1);
		end else if (wr) begin
			unique case (idx)
				pmag_pkg::REG_WIDTH:  width_q  <= pwdata[pmag_pkg::DIM_W-1:0];
				pmag_pkg::REG_HEIGHT: height_q <= pwdata[pmag_pkg::DIM_W-1:0];
				pmag_pkg::REG_STEP:   step_q   <= pwdata[pmag_pkg::STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			pmag_pkg::REG_WIDTH:  prdata = pmag_pkg::CFG_DW'(width_q);
			pmag_pkg::REG_HEIGHT: prdata = pmag_pkg::CFG_DW'(height_q);
			pmag_pkg::REG_STEP:   prdata = pmag_pkg::CFG_DW'(signed'(step_q));
			default:              prdata = '0;
		endcase
	end

	function automatic logic [pmag_pkg::DIM_W-1:0] clamp_dim(input logic [pmag_pkg::DIM_W-1:0] d);
		if (d == '0)
			return pmag_pkg::DIM_W'(1);
		else if (32'(d) > DIM_MAX)
			return pmag_pkg::DIM_W'(DIM_MAX);
		else
			return d;
	endfunction

	assign cfg.width  = clamp_dim(width_q);
	assign cfg.height = clamp_dim(height_q);
	assign cfg.step   = step_q;

endmodule

// ===== hw/rtl/pmag_mul.sv =====
// shared signed multiplier with registered product
module pmag_mul (
	input  logic                                clk,
	input  logic signed [pmag_pkg::MUL_W-1:0]   op_a,
	input  logic signed [pmag_pkg::MUL_W-1:0]   op_b,
	output logic signed [pmag_pkg::PROD_W-1:0]  prod
);

	logic signed [pmag_pkg::PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

	assign prod = prod_q;

endmodule

// ===== hw/rtl/pmag_mod.sv =====
// bit-serial restoring remainder, one dividend bit per cycle
module pmag_mod (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [pmag_pkg::DIV_BITS-1:0]     dividend,
	input  logic [pmag_pkg::N_W-1:0]          divisor,
	output pmag_pkg::mod_stat_t               stat,
	output logic [pmag_pkg::N_W-1:0]          remainder
);

	logic                            busy_q;
	logic                            done_q;
	logic [pmag_pkg::CNT_W-1:0]      cnt_q;
	logic [pmag_pkg::DIV_BITS-1:0]   div_q;
	logic [pmag_pkg::N_W-1:0]        den_q;
	logic [pmag_pkg::N_W-1:0]        rem_q;
	logic [pmag_pkg::N_W:0]          trial;
	logic [pmag_pkg::N_W:0]          diff;
	logic [pmag_pkg::N_W-1:0]        rem_nxt;

	// shift in next dividend bit, subtract divisor when it fits
	assign trial   = {rem_q, div_q[pmag_pkg::DIV_BITS-1]};
	assign diff    = trial - {1'b0, den_q};
	assign rem_nxt = (trial >= {1'b0, den_q}) ? diff[pmag_pkg::N_W-1:0] : trial[pmag_pkg::N_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= pmag_pkg::CNT_W'(pmag_pkg::DIV_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - pmag_pkg::CNT_W'(1);
				if (cnt_q == pmag_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			div_q <= {div_q[pmag_pkg::DIV_BITS-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign remainder = rem_q;

endmodule

// ===== hw/rtl/poly_matrix_address_gen.sv =====
// top level: sequencer around a shared multiplier and a serial remainder unit
// an accepted input word runs S_NMUL, S_OP1 and those of S_OP2 to S_OP5 that its mode
//   needs, then reduces modulo the cell count in S_MODS and S_MODW (skipped if negative)
//   and ends in S_PUSH; s_tready is high only while the sequencer is idle, so a new word
//   waits until the last is pushed; the finished result waits in its own output register
// reset: arst_n clears sequencer, channel, previous address and config (16 x 16, step 1)
module poly_matrix_address_gen #(
	parameter int CHANNELS = 16,
	parameter int DIM_MAX  = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// apb configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pmag_pkg::CFG_AW-1:0]   paddr,
	input  logic [pmag_pkg::CFG_DW-1:0]   pwdata,
	output logic [pmag_pkg::CFG_DW-1:0]   prdata,
	output logic                          pready,
	// input words
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [55:0]                   s_tdata,  // x_offset[9:0], y_offset[19:10],
	                                                // x_level[36:20], y_level[53:37], zero
	input  logic [1:0]                    s_tuser,  // has_x[0], has_y[1]
	// result words
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [15:0]                   m_tdata,  // address[15:0]
	output logic                          m_tlast
);

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_NMUL = 10'b0000000010,
		S_OP1  = 10'b0000000100,
		S_OP2  = 10'b0000001000,
		S_OP3  = 10'b0000010000,
		S_OP4  = 10'b0000100000,
		S_OP5  = 10'b0001000000,
		S_MODS = 10'b0010000000,
		S_MODW = 10'b0100000000,
		S_PUSH = 10'b1000000000
	} state_t;

	// how the raw address is formed for the current channel
	typedef enum logic [1:0] {
		MODE_XY   = 2'd0,  // y level present, x level optional
		MODE_X    = 2'd1,  // x level spread over the whole matrix
		MODE_STEP = 2'd2,  // previous address plus step
		MODE_BASE = 2'd3   // plain base position
	} mode_t;

	pmag_pkg::cfg_t      cfg;
	pmag_pkg::mod_stat_t mod_stat;

	state_t state_q;
	mode_t  mode_q;
	mode_t  mode_in;

	logic                                  hx_q;
	logic signed [pmag_pkg::OFF_W-1:0]     xo_q;
	logic signed [pmag_pkg::OFF_W-1:0]     yo_q;
	logic signed [pmag_pkg::LVL_W-1:0]     xl_q;
	logic signed [pmag_pkg::LVL_W-1:0]     yl_q;
	logic [CH_W-1:0]                       ch_q;
	logic [pmag_pkg::N_W-1:0]              prev_q;
	logic [pmag_pkg::N_W-1:0]              n_q;
	logic [pmag_pkg::N_W-1:0]              res_q;
	logic signed [pmag_pkg::COORD_W-1:0]   coord_q;
	logic signed [pmag_pkg::ACC_W-1:0]     acc_q;
	logic                                  out_valid_q;
	logic [pmag_pkg::ADDR_W-1:0]           out_addr_q;
	logic                                  out_last_q;

	logic signed [pmag_pkg::MUL_W-1:0]     mul_a;
	logic signed [pmag_pkg::MUL_W-1:0]     mul_b;
	logic signed [pmag_pkg::PROD_W-1:0]    prod;
	logic signed [pmag_pkg::TRUNC_W-1:0]   prod_tr;
	logic signed [pmag_pkg::TRUNC_W-1:0]   row_tr;
	logic signed [pmag_pkg::PROD_W-1:0]    yo_sh;
	logic signed [pmag_pkg::ACC_W-1:0]     xo_ext;
	logic signed [pmag_pkg::ACC_W-1:0]     step_sum;
	logic [pmag_pkg::N_W-1:0]              remainder;
	logic                                  mod_start;
	logic                                  in_fire;
	logic                                  out_fire;
	logic                                  push;
	logic                                  last_ch;

	assign pready = 1'b1;

	pmag_cfg #(
		.DIM_MAX(DIM_MAX)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.cfg    (cfg)
	);

	pmag_mul u_mul (
		.clk (clk),
		.op_a(mul_a),
		.op_b(mul_b),
		.prod(prod)
	);

	pmag_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (acc_q[pmag_pkg::DIV_BITS-1:0]),
		.divisor  (n_q),
		.stat     (mod_stat),
		.remainder(remainder)
	);

	assign s_tready = (state_q == S_IDLE);
	assign in_fire  = s_tvalid & s_tready;
	assign out_fire = out_valid_q & m_tready;
	// the finished result moves into the output register once it is free
	assign push     = (state_q == S_PUSH) & (~out_valid_q | m_tready);
	assign last_ch  = (ch_q == CH_W'(CHANNELS - 1));

	// a negative raw address maps to zero without running the remainder unit
	assign mod_start = (state_q == S_MODS) & ~acc_q[pmag_pkg::ACC_W-1];

	always_comb begin
		if (s_tuser[1])
			mode_in = MODE_XY;
		else if (s_tuser[0])
			mode_in = MODE_X;
		else if (ch_q != '0)
			mode_in = MODE_STEP;
		else
			mode_in = MODE_BASE;
	end

	// scaled values from the multiplier, rounded toward zero
	assign prod_tr  = pmag_pkg::trunc_frac(prod);
	assign yo_sh    = {{(pmag_pkg::PROD_W - pmag_pkg::OFF_W - pmag_pkg::FRAC){yo_q[pmag_pkg::OFF_W-1]}},
		yo_q, {pmag_pkg::FRAC{1'b0}}};
	assign row_tr   = pmag_pkg::trunc_frac(yo_sh + prod);
	assign xo_ext   = {{(pmag_pkg::ACC_W - pmag_pkg::OFF_W){xo_q[pmag_pkg::OFF_W-1]}}, xo_q};
	assign step_sum = {{(pmag_pkg::ACC_W - pmag_pkg::N_W){1'b0}}, prev_q}
		+ {{(pmag_pkg::ACC_W - pmag_pkg::STEP_W){cfg.step[pmag_pkg::STEP_W-1]}}, cfg.step};

	// operand select for the shared multiplier, product is registered and lands in the next cycle
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_NMUL: begin
				mul_a = {{(pmag_pkg::MUL_W - pmag_pkg::DIM_W){1'b0}}, cfg.width};
				mul_b = {{(pmag_pkg::MUL_W - pmag_pkg::DIM_W){1'b0}}, cfg.height};
			end
			S_OP1: begin
				if (mode_q == MODE_XY) begin
					mul_a = {{(pmag_pkg::MUL_W - pmag_pkg::LVL_W){yl_q[pmag_pkg::LVL_W-1]}}, yl_q};
					mul_b = {{(pmag_pkg::MUL_W - pmag_pkg::DIM_W){1'b0}}, cfg.height};
				end else begin
					mul_a = {{(pmag_pkg::MUL_W - pmag_pkg::DIM_W){1'b0}}, cfg.width};
					mul_b = {{(pmag_pkg::MUL_W - pmag_pkg::OFF_W){yo_q[pmag_pkg::OFF_W-1]}}, yo_q};
				end
			end
			S_OP2: begin
				// spread over n-1 cells for the x-only channel
				mul_a = {{(pmag_pkg::MUL_W - pmag_pkg::LVL_W){xl_q[pmag_pkg::LVL_W-1]}}, xl_q};
				mul_b = {1'b0, n_q - pmag_pkg::N_W'(1)};
			end
			S_OP3: begin
				mul_a = {{(pmag_pkg::MUL_W - pmag_pkg::DIM_W){1'b0}}, cfg.width};
				mul_b = {{(pmag_pkg::MUL_W - pmag_pkg::COORD_W){coord_q[pmag_pkg::COORD_W-1]}}, coord_q};
			end
			S_OP4: begin
				mul_a = {{(pmag_pkg::MUL_W - pmag_pkg::LVL_W){xl_q[pmag_pkg::LVL_W-1]}}, xl_q};
				mul_b = {{(pmag_pkg::MUL_W - pmag_pkg::DIM_W){1'b0}}, cfg.width};
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= MODE_BASE;
			ch_q        <= '0;
			prev_q      <= '0;
			n_q         <= pmag_pkg::N_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (push)
				out_valid_q <= 1'b1;
			else if (out_fire)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						mode_q  <= mode_in;
						state_q <= S_NMUL;
					end
				end
				S_NMUL: state_q <= S_OP1;
				S_OP1: begin
					n_q <= prod[pmag_pkg::N_W-1:0];
					state_q <= (mode_q == MODE_STEP) ? S_MODS : S_OP2;
				end
				S_OP2: state_q <= (mode_q == MODE_BASE) ? S_MODS : S_OP3;
				S_OP3: state_q <= (mode_q == MODE_XY) ? S_OP4 : S_MODS;
				S_OP4: state_q <= hx_q ? S_OP5 : S_MODS;
				S_OP5: state_q <= S_MODS;
				S_MODS: state_q <= acc_q[pmag_pkg::ACC_W-1] ? S_PUSH : S_MODW;
				S_MODW: begin
					if (mod_stat.done)
						state_q <= S_PUSH;
				end
				S_PUSH: begin
					if (push) begin
						prev_q  <= res_q;
						ch_q    <= last_ch ? '0 : ch_q + CH_W'(1);
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			xo_q <= s_tdata[9:0];
			yo_q <= s_tdata[19:10];
			xl_q <= s_tdata[36:20];
			yl_q <= s_tdata[53:37];
			hx_q <= s_tuser[0];
		end

		case (state_q)
			S_OP1: begin
				if (mode_q == MODE_STEP)
					acc_q <= step_sum;
			end
			S_OP2: begin
				if (mode_q == MODE_XY)
					coord_q <= row_tr[pmag_pkg::COORD_W-1:0];
				else
					acc_q <= xo_ext + prod[pmag_pkg::ACC_W-1:0];
			end
			S_OP3: begin
				if (mode_q == MODE_X)
					acc_q <= acc_q + prod_tr[pmag_pkg::ACC_W-1:0];
			end
			S_OP4: acc_q <= xo_ext + prod[pmag_pkg::ACC_W-1:0];
			S_OP5: acc_q <= acc_q + prod_tr[pmag_pkg::ACC_W-1:0];
			S_MODS: begin
				if (acc_q[pmag_pkg::ACC_W-1])
					res_q <= '0;
			end
			S_MODW: begin
				if (mod_stat.done)
					res_q <= remainder;
			end
			default: ;
		endcase

		if (push) begin
			out_addr_q <= res_q[pmag_pkg::ADDR_W-1:0];
			out_last_q <= last_ch;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_addr_q;
	assign m_tlast  = out_last_q;

	// an accepted word always starts the sequence with the cell count multiply
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == S_NMUL))
		else $error("accepted word did not start the sequence");

	// the remainder unit is never restarted while it is still working
	a_mod_free: assert property (@(posedge clk) disable iff (!arst_n)
		mod_start |-> !mod_stat.busy)
		else $error("remainder unit restarted while busy");

	// a negative raw address yields address zero
	a_neg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MODS && acc_q[pmag_pkg::ACC_W-1]) |=> (res_q == '0))
		else $error("negative raw address not clamped to zero");

	// the delivered address stays inside the matrix
	a_addr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (prev_q < n_q))
		else $error("address beyond cell count");

endmodule
